### rtl/dwrd_pkg.sv
// Shared types and constants for the deque with run collapse.
// Used by dwrd_ctrl and the top level; depends on nothing.
package dwrd_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 64;
	localparam int WORD_W        = 64;
	localparam int ENTRIES_W     = 5;
	localparam int OPCODE_W      = 3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_L   = 3'd0,
		OP_PUSH_R   = 3'd1,
		OP_POP_L    = 3'd2,
		OP_POP_R    = 3'd3,
		OP_COLLAPSE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_COL_RD,
		S_COL_CHK,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0]    popped;
		status_t              status;
		logic [ENTRIES_W-1:0] entries;
		logic                 empty_res;
	} res_t;

endpackage

### rtl/dwrd_ram.sv
// Generic single-port RAM with registered read data.
// Holds the ring store; no dependencies.
module dwrd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/dwrd_addr.sv
// Shared ring address unit: (front + offset) mod DEPTH with one compare-subtract.
// No dependencies.
module dwrd_addr #(
	parameter int DEPTH = 16
) (
	input  logic [$clog2(DEPTH)-1:0] front,
	input  logic [$clog2(DEPTH)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0] pos
);

	localparam int IDX_W = $clog2(DEPTH);

	logic [IDX_W:0] sum;
	logic [IDX_W:0] wrapped;

	always_comb begin
		sum     = {1'b0, front} + {1'b0, offset};
		wrapped = sum - (IDX_W + 1)'(DEPTH);
		pos     = (sum >= (IDX_W + 1)'(DEPTH)) ? wrapped[IDX_W-1:0] : sum[IDX_W-1:0];
	end

endmodule

### rtl/dwrd_ctrl.sv
// Sequencer for the deque: end pointers, operation decode and the collapse walk.
// Depends on dwrd_pkg; drives dwrd_addr and dwrd_ram from the top level.
module dwrd_ctrl
	import dwrd_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OPCODE_W-1:0]      opcode,
	input  logic [WORD_W-1:0]        value,
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_t                     res,
	output logic [$clog2(DEPTH)-1:0] front,
	output logic [$clog2(DEPTH)-1:0] offset,
	input  logic [$clog2(DEPTH)-1:0] pos,
	output logic                     ram_we,
	output logic [WORD_BITS-1:0]     ram_wdata,
	input  logic [WORD_BITS-1:0]     ram_rdata
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t               state_q, state_d;
	op_t                  op_q;
	logic [WORD_BITS-1:0] value_q;
	logic [WORD_BITS-1:0] last_q;
	logic [WORD_W-1:0]    popped_q;
	status_t              status_q;
	logic [IDX_W-1:0]     front_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     kept_q;

	logic full;
	logic empty;
	logic k_last;
	logic keep;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign k_last = (CNT_W'(k_q + 1'b1) == count_q);
	assign keep   = (kept_q == '0) || (ram_rdata != last_q);
	assign front  = front_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (op_q)
					OP_POP_L, OP_POP_R: state_d = empty ? S_REPORT : S_POP_WAIT;
					OP_COLLAPSE:        state_d = (count_q > CNT_W'(1)) ? S_COL_RD : S_REPORT;
					default:            state_d = S_REPORT;
				endcase
			end
			S_POP_WAIT: state_d = S_REPORT;
			S_COL_RD:   state_d = S_COL_CHK;
			S_COL_CHK:  state_d = k_last ? S_REPORT : S_COL_RD;
			S_REPORT: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		res_valid = (state_q == S_REPORT);
		offset    = '0;
		ram_we    = 1'b0;
		ram_wdata = value_q;
		unique case (state_q)
			S_EXEC: begin
				unique case (op_q)
					OP_PUSH_L: begin
						offset = IDX_W'(DEPTH - 1);
						ram_we = !full;
					end
					OP_PUSH_R: begin
						offset = IDX_W'(count_q);
						ram_we = !full;
					end
					OP_POP_R: offset = IDX_W'(count_q - 1'b1);
					default:  offset = '0;
				endcase
			end
			S_POP_WAIT: offset = IDX_W'(1);
			S_COL_RD:   offset = k_q[IDX_W-1:0];
			S_COL_CHK: begin
				offset    = kept_q[IDX_W-1:0];
				ram_we    = keep;
				ram_wdata = ram_rdata;
			end
			default: offset = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_EXEC: begin
					if ((op_q == OP_PUSH_L || op_q == OP_PUSH_R) && !full) begin
						count_q <= count_q + 1'b1;
						if (op_q == OP_PUSH_L) front_q <= pos;
					end
				end
				S_POP_WAIT: begin
					count_q <= count_q - 1'b1;
					if (op_q == OP_POP_L) front_q <= pos;
				end
				S_COL_CHK: begin
					if (k_last) count_q <= keep ? CNT_W'(kept_q + 1'b1) : kept_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q     <= op_t'(opcode);
				value_q  <= value[WORD_BITS-1:0];
				popped_q <= '0;
				status_q <= STAT_OK;
			end
			S_EXEC: begin
				k_q    <= '0;
				kept_q <= '0;
				unique case (op_q)
					OP_PUSH_L, OP_PUSH_R: begin
						if (full) status_q <= STAT_PUSH_FULL;
					end
					OP_POP_L, OP_POP_R: begin
						if (empty) status_q <= STAT_POP_EMPTY;
					end
					default: ;
				endcase
			end
			S_POP_WAIT: popped_q <= WORD_W'(ram_rdata);
			S_COL_CHK: begin
				k_q <= k_q + 1'b1;
				if (keep) begin
					kept_q <= kept_q + 1'b1;
					last_q <= ram_rdata;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.popped    = popped_q;
		res.status    = status_q;
		res.entries   = ENTRIES_W'(count_q);
		res.empty_res = empty;
	end

endmodule

### rtl/deque_with_run_dedup.sv
// Top level of the bounded deque with run collapse: stream ports and result register.
// Depends on dwrd_pkg, dwrd_ram, dwrd_addr and dwrd_ctrl.
//
// One transaction in gives one transaction out. The store is a single-port RAM with
// registered read, and every ring address goes through one shared adder, so work is
// serialized: a transaction is accepted in idle, executed and then reported before the
// next acceptance; a pop on a non-empty deque adds a wait for the read data, and a
// collapse with more than one entry held walks the entries, each walk step being one
// RAM read and one compare-and-write. A result waiting on the master side does not
// block the next acceptance; completion stalls only if it is still waiting.
// The store has no reset; only held entries are ever read.
module deque_with_run_dedup
	import dwrd_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [WORD_W-1:0]   s_tdata,  // [63:0] value
	input  logic [OPCODE_W-1:0] s_tuser,  // [2:0] opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [71:0]         m_tdata,  // [63:0] popped, [68:64] entries, [71:69] zero
	output logic [2:0]          m_tuser   // [1:0] status, [2] empty_res
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                 res_valid;
	logic                 res_ready;
	res_t                 res;
	logic [IDX_W-1:0]     front;
	logic [IDX_W-1:0]     offset;
	logic [IDX_W-1:0]     pos;
	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;
	logic                 out_valid_q;
	res_t                 out_q;

	dwrd_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.opcode    (s_tuser),
		.value     (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.front     (front),
		.offset    (offset),
		.pos       (pos),
		.ram_we    (ram_we),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	dwrd_addr #(
		.DEPTH (DEPTH)
	) u_addr (
		.front  (front),
		.offset (offset),
		.pos    (pos)
	);

	dwrd_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (pos),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.entries, out_q.popped};
	assign m_tuser  = {out_q.empty_res, out_q.status};

	a_fail_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == STAT_POP_EMPTY |-> out_q.popped == '0)
		else $error("failed pop returned a nonzero word");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == STAT_PUSH_FULL |-> !out_q.empty_res)
		else $error("push on full reported an empty deque");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a transaction while one is in progress");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid)
		else $error("result offered twice for one transaction");

endmodule
